FILE: hw/rtl/utf8_to_utf16_transcoder_assert.svh
// assertion macros for the utf-8 to utf-16 transcoder
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define U8U16_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/u8u16_pkg.sv
// shared types, constants and helpers for the utf-8 to utf-16 transcoder
// no dependencies
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam int unsigned CmdDepth = 2;

  localparam logic [15:0] ReplUnit  = 16'hFFFD;
  localparam logic [20:0] MaxCp     = 21'h10FFFF;
  localparam logic [20:0] SurrLo    = 21'h00D800;
  localparam logic [20:0] SurrHi    = 21'h00DFFF;
  localparam logic [20:0] SuppBase  = 21'h010000;
  localparam logic [20:0] Min2Byte  = 21'h000080;
  localparam logic [20:0] Min3Byte  = 21'h000800;
  localparam logic [20:0] BmpMax    = 21'h00FFFF;
  localparam logic [15:0] HiSurrTag = 16'hD800;
  localparam logic [15:0] LoSurrTag = 16'hDC00;

  // sequence length codes
  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] Len2    = 3'd2;
  localparam logic [2:0] Len3    = 3'd3;
  localparam logic [2:0] Len4    = 3'd4;

  // one command: rep_cnt replacement units, then the rest from unit0/unit1
  typedef struct packed {
    logic [2:0]  rep_cnt;
    logic [2:0]  unit_cnt;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        last;
  } u8u16_cmd_t;

  function automatic logic cp_ok(logic [20:0] cp, logic [2:0] len);
    logic ok;
    ok = 1'b1;
    if (len == Len2 && cp < Min2Byte) ok = 1'b0;
    if (len == Len3 && cp < Min3Byte) ok = 1'b0;
    if (len == Len4 && cp < SuppBase) ok = 1'b0;
    if (cp > MaxCp) ok = 1'b0;
    if (cp >= SurrLo && cp <= SurrHi) ok = 1'b0;
    return ok;
  endfunction

endpackage

FILE: hw/rtl/utf8_to_utf16_transcoder.sv
// a byte's command is queued, and its first unit shows once that command heads the queue
// throughput: one byte per cycle while each byte yields at most one code unit and the
// receiver keeps up; a byte yielding more units (surrogate pair, replacement run) holds
// the sequencer for one transfer per unit, the command queue absorbing the difference
// reset: asynchronous, clears the pending sequence, the queue and the unit index
`timescale 1ns / 1ps
`include "utf8_to_utf16_transcoder_assert.svh"

module utf8_to_utf16_transcoder #(
  parameter int unsigned CMD_DEPTH = u8u16_pkg::CmdDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte side, queue style
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // code unit side, queue style
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit_o,
  output logic        last_unit_o
);
  import u8u16_pkg::*;

  // command from classifier into the queue, head of the queue to the sequencer
  u8u16_cmd_t cmd_in, cmd_head;
  logic       cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic       seq_pending;

  // front: one byte per transfer, decides replacements and final units up front
  u8u16_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (cmd_full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .cmd_o       (cmd_in),
    .cmd_push_o  (cmd_push),
    .pending_o   (seq_pending)
  );

  // short queue lets the byte side keep going while a multi-unit command drains
  u8u16_cmd_fifo #(
    .Depth (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_push),
    .wr_data_i (cmd_in),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_head),
    .full_o    (cmd_full),
    .empty_o   (cmd_empty)
  );

  // back: expands the head command one code unit per transfer
  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .code_unit_o (code_unit_o),
    .last_unit_o (last_unit_o)
  );

  // the classifier stalls on a full queue, so byte transfers and queue space agree
  assign full = cmd_full;

  // a command is never written into a full queue
  `U8U16_ASSERT_IMPL(a_no_overflow, cmd_push, !cmd_full, "command pushed into full queue")

  // the head command retires only on a result transfer
  `U8U16_ASSERT_IMPL(a_pop_on_xfer, cmd_pop, pop && !empty, "command retired without transfer")

  // a final byte always leaves no sequence pending
  `U8U16_ASSERT_NEXT(a_idle_after_last, push && !full && last_byte_i, !seq_pending,
                     "sequence still pending after final byte")

endmodule

FILE: hw/rtl/u8u16_cmd_fifo.sv
// command queue between the byte classifier and the unit sequencer
// depends on u8u16_pkg
`timescale 1ns / 1ps

module u8u16_cmd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  u8u16_pkg::u8u16_cmd_t  wr_data_i,
  input  logic                   rd_en_i,
  output u8u16_pkg::u8u16_cmd_t  rd_data_o,
  output logic                   full_o,
  output logic                   empty_o
);
  import u8u16_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  u8u16_cmd_t mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    unique case ({do_wr, do_rd})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: hw/rtl/u8u16_front.sv
// byte classifier: tracks the pending sequence and turns each byte into a command
// depends on u8u16_pkg
`timescale 1ns / 1ps

module u8u16_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic                   full_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  output u8u16_pkg::u8u16_cmd_t  cmd_o,
  output logic                   cmd_push_o,
  output logic                   pending_o
);
  import u8u16_pkg::*;

  logic [2:0]  exp_len_q, exp_len_d;
  logic [1:0]  seen_q, seen_d;
  logic [14:0] part_q, part_d;

  logic        accept, is_cont, decode_lead;
  logic [2:0]  seen_next, rep, tail;
  logic [20:0] cp_new, cp_off;
  logic [15:0] u0, u1;

  assign accept    = push_i && !full_i;
  assign is_cont   = (data_byte_i[7:6] == 2'b10);
  assign cp_new    = {part_q, data_byte_i[5:0]};
  assign cp_off    = cp_new - SuppBase;
  assign seen_next = {1'b0, seen_q} + 3'd1;
  assign pending_o = (exp_len_q != LenNone);

  always_comb begin
    exp_len_d   = exp_len_q;
    seen_d      = seen_q;
    part_d      = part_q;
    rep         = '0;
    tail        = '0;
    u0          = '0;
    u1          = '0;
    decode_lead = 1'b1;

    if (pending_o) begin
      if (is_cont) begin
        decode_lead = 1'b0;
        if (seen_next >= exp_len_q) begin
          if (cp_ok(cp_new, exp_len_q)) begin
            if (cp_new <= BmpMax) begin
              tail = 3'd1;
              u0   = cp_new[15:0];
            end else begin
              tail = 3'd2;
              u0   = HiSurrTag | {6'b0, cp_off[19:10]};
              u1   = LoSurrTag | {6'b0, cp_off[9:0]};
            end
          end else begin
            rep = exp_len_q;
          end
          exp_len_d = LenNone;
          seen_d    = '0;
          part_d    = '0;
        end else if (last_byte_i) begin
          rep       = seen_next;
          exp_len_d = LenNone;
          seen_d    = '0;
          part_d    = '0;
        end else begin
          seen_d = seen_next[1:0];
          part_d = cp_new[14:0];
        end
      end else begin
        // broken sequence: flush buffered bytes, then take this byte as a lead
        rep       = {1'b0, seen_q};
        exp_len_d = LenNone;
        seen_d    = '0;
        part_d    = '0;
      end
    end

    if (decode_lead) begin
      priority if (!data_byte_i[7]) begin
        tail = 3'd1;
        u0   = {8'h00, data_byte_i};
      end else if (data_byte_i[7:5] == 3'b110 || data_byte_i[7:4] == 4'b1110 ||
                   data_byte_i[7:3] == 5'b11110) begin
        if (last_byte_i) begin
          tail = 3'd1;
          u0   = ReplUnit;
        end else begin
          seen_d = 2'd1;
          priority if (data_byte_i[7:5] == 3'b110) begin
            exp_len_d = Len2;
            part_d    = {10'b0, data_byte_i[4:0]};
          end else if (data_byte_i[7:4] == 4'b1110) begin
            exp_len_d = Len3;
            part_d    = {11'b0, data_byte_i[3:0]};
          end else begin
            exp_len_d = Len4;
            part_d    = {12'b0, data_byte_i[2:0]};
          end
        end
      end else begin
        tail = 3'd1;
        u0   = ReplUnit;
      end
    end
  end

  always_comb begin
    cmd_o.rep_cnt  = rep;
    cmd_o.unit_cnt = rep + tail;
    cmd_o.unit0    = u0;
    cmd_o.unit1    = u1;
    cmd_o.last     = last_byte_i;
  end

  assign cmd_push_o = accept && (cmd_o.unit_cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= LenNone;
      seen_q    <= '0;
      part_q    <= '0;
    end else if (accept) begin
      exp_len_q <= exp_len_d;
      seen_q    <= seen_d;
      part_q    <= part_d;
    end
  end

endmodule

FILE: hw/rtl/u8u16_back.sv
// unit sequencer: walks the head command and presents one code unit at a time
// depends on u8u16_pkg
`timescale 1ns / 1ps

module u8u16_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  u8u16_pkg::u8u16_cmd_t  cmd_i,
  input  logic                   cmd_empty_i,
  output logic                   cmd_pop_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output logic [15:0]            code_unit_o,
  output logic                   last_unit_o
);
  import u8u16_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic [2:0] idx_ext;
  logic       final_unit, xfer;

  assign idx_ext    = {1'b0, idx_q};
  assign final_unit = (idx_ext == cmd_i.unit_cnt - 3'd1);
  assign empty_o    = cmd_empty_i;
  assign xfer       = pop_i && !cmd_empty_i;
  assign cmd_pop_o  = xfer && final_unit;

  always_comb begin
    priority if (idx_ext < cmd_i.rep_cnt) begin
      code_unit_o = ReplUnit;
    end else if (idx_ext == cmd_i.rep_cnt) begin
      code_unit_o = cmd_i.unit0;
    end else begin
      code_unit_o = cmd_i.unit1;
    end
    last_unit_o = cmd_i.last && final_unit;

    idx_d = idx_q;
    if (xfer) begin
      idx_d = final_unit ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

FILE: verif/utf16_unit_checker.sv
// checker for the utf-8 to utf-16 transcoder: watches the byte and code unit queues,
// predicts the code units of every byte transfer and compares them in order
// depends on u8u16_pkg for the code point limits and the sequence length codes
`timescale 1ns / 1ps

module utf16_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [15:0] code_unit,
  input  logic        last_unit,
  output int          error_count,
  output int          units_waiting,
  output int          units_checked
);
  import u8u16_pkg::*;

  typedef struct packed {
    logic [15:0] unit;
    logic        last;
  } utf16_result_t;

  // decoder state of the prediction
  logic [2:0]  pend_len;
  logic [1:0]  pend_seen;
  logic [20:0] pend_cp;

  utf16_result_t expected_units [$];
  int            mismatches;
  int            checked;

  function automatic logic cp_legal(logic [20:0] cp, logic [2:0] seq_len);
    logic ok;
    ok = (cp <= MaxCp) && !(cp >= SurrLo && cp <= SurrHi);
    case (seq_len)
      Len2: if (cp < Min2Byte) ok = 1'b0;
      Len3: if (cp < Min3Byte) ok = 1'b0;
      Len4: if (cp < SuppBase) ok = 1'b0;
      default: ;
    endcase
    return ok;
  endfunction

  // one byte gives at most four units
  task automatic predict_units(input logic [7:0] b, input logic fin);
    logic [15:0]   units [4];
    int            n_units;
    logic [20:0]   cp;
    logic [20:0]   off;
    logic [2:0]    seen;
    logic [2:0]    lead_len;
    logic          as_lead;
    int            repl_cnt;
    int            i;
    utf16_result_t r;
    as_lead  = 1'b1;
    repl_cnt = 0;
    n_units  = 0;
    cp       = '0;
    if (pend_len != LenNone) begin
      if (b[7:6] == 2'b10) begin
        cp      = {pend_cp[14:0], b[5:0]};
        seen    = {1'b0, pend_seen} + 3'd1;
        as_lead = 1'b0;
        if (seen >= pend_len) begin
          if (cp_legal(cp, pend_len)) begin
            if (cp <= BmpMax) begin
              units[n_units] = cp[15:0];
              n_units++;
            end else begin
              // surrogate pair, high half first
              off = cp - SuppBase;
              units[n_units] = HiSurrTag + {6'd0, off[19:10]};
              n_units++;
              units[n_units] = LoSurrTag + {6'd0, off[9:0]};
              n_units++;
            end
          end else begin
            repl_cnt = pend_len;
          end
          pend_len  = LenNone;
          pend_seen = '0;
          pend_cp   = '0;
        end else if (fin) begin
          repl_cnt  = seen;
          pend_len  = LenNone;
          pend_seen = '0;
          pend_cp   = '0;
        end else begin
          pend_seen = seen[1:0];
          pend_cp   = cp;
        end
      end else begin
        // sequence broken off, the byte is decoded again as a lead
        repl_cnt  = pend_seen;
        pend_len  = LenNone;
        pend_seen = '0;
        pend_cp   = '0;
      end
    end
    for (i = 0; i < repl_cnt; i++) begin
      units[n_units] = ReplUnit;
      n_units++;
    end
    if (as_lead) begin
      lead_len = LenNone;
      if (!b[7]) begin
        units[n_units] = {8'd0, b};
        n_units++;
      end else if (b[7:5] == 3'b110) begin
        lead_len = Len2;
        cp       = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        lead_len = Len3;
        cp       = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        lead_len = Len4;
        cp       = {18'd0, b[2:0]};
      end else begin
        units[n_units] = ReplUnit;
        n_units++;
      end
      if (lead_len != LenNone) begin
        if (fin) begin
          units[n_units] = ReplUnit;
          n_units++;
        end else begin
          pend_len  = lead_len;
          pend_seen = 2'd1;
          pend_cp   = cp;
        end
      end
    end
    for (i = 0; i < n_units; i++) begin
      r.unit = units[i];
      r.last = fin && (i == n_units - 1);
      expected_units.insert(expected_units.size(), r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    utf16_result_t want;
    if (!rst_ni) begin
      pend_len   = LenNone;
      pend_seen  = '0;
      pend_cp    = '0;
      mismatches = 0;
      checked    = 0;
      expected_units.delete();
      error_count   <= 0;
      units_waiting <= 0;
      units_checked <= 0;
    end else begin
      // results first: a unit on the port always comes from an earlier byte
      if (pop && !empty) begin
        if (expected_units.size() == 0) begin
          $error("code_unit %h with last_unit %b arrived with nothing expected",
                 code_unit, last_unit);
          mismatches++;
        end else begin
          want = expected_units.pop_front();
          if (code_unit !== want.unit) begin
            $error("code_unit mismatch: expected %h, actual %h", want.unit, code_unit);
            mismatches++;
          end
          if (last_unit !== want.last) begin
            $error("last_unit mismatch: expected %b, actual %b", want.last, last_unit);
            mismatches++;
          end
          checked++;
        end
      end
      if (push && !full) predict_units(data_byte, last_byte);
      error_count   <= mismatches;
      units_waiting <= expected_units.size();
      units_checked <= checked;
    end
  end

endmodule

FILE: verif/tb.sv
// top of the utf-8 to utf-16 transcoder testbench: clock, reset, byte stimulus, verdict
// depends on utf16_unit_checker and the transcoder rtl with its package
`timescale 1ns / 1ps

module tb;

  // generous ceiling for the watchdog
  localparam int CycleLimit  = 60000;
  localparam int DrainCycles = 20;
  localparam int RandBytes   = 260;

  // directed text: smallest ascii, smallest two-byte, largest code point as a pair,
  // stray continuation, bad lead, sequence broken by ascii, overlong,
  // encoded surrogate, value above the range, then cut off at the last byte
  localparam int DirLen = 24;
  localparam logic [DirLen*8-1:0] DirectedText = {
    8'h00, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h80, 8'hFF, 8'hE2, 8'h82, 8'h41,
    8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80
  };

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        empty;
  logic        pop       = 1'b0;
  logic [15:0] code_unit;
  logic        last_unit;

  int error_count;
  int units_waiting;
  int units_checked;

  // idle percentages of both sides, changed between phases
  int send_idle_pct = 30;
  int recv_idle_pct = 53;

  int cycle_cnt   = 0;
  int bytes_sent  = 0;
  int texts_sent  = 0;
  int rand_bytes  = 0;

  // bytes of the string being built
  logic [7:0] text [$];

  always #6 clk_i = ~clk_i;

  utf8_to_utf16_transcoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte),
    .last_byte_i (last_byte),
    .empty       (empty),
    .pop         (pop),
    .code_unit_o (code_unit),
    .last_unit_o (last_unit)
  );

  utf16_unit_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .empty         (empty),
    .pop           (pop),
    .code_unit     (code_unit),
    .last_unit     (last_unit),
    .error_count   (error_count),
    .units_waiting (units_waiting),
    .units_checked (units_checked)
  );

  // receiver: one pop decision per edge
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d code units still expected",
               cycle_cnt, units_waiting);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one byte transfer; push is touched once per edge so a back-to-back
  // transfer keeps it high without a glitch
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    // full is sampled before the edge updates it
    do @(posedge clk_i); while (full);
    bytes_sent++;
  endtask

  // send the built string, last_byte on its final byte
  task automatic send_text();
    int i;
    int n;
    n = text.size();
    for (i = 0; i < n; i++) send_byte(text[i], i == n - 1);
    texts_sent++;
    text.delete();
  endtask

  // add one byte at the end of the string being built
  task automatic append_byte(input logic [7:0] b);
    text.insert(text.size(), b);
  endtask

  // append cp in an encoding of nbytes, whether or not that form is legal
  task automatic put_encoded(input logic [20:0] cp, input int nbytes);
    case (nbytes)
      1: append_byte({1'b0, cp[6:0]});
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // well-formed character of a random length class
  task automatic put_valid_char();
    logic [20:0] cp;
    int          nbytes;
    nbytes = $urandom_range(4, 1);
    case (nbytes)
      1: cp = 21'($urandom_range(21'h7F, 0));
      2: cp = 21'($urandom_range(21'h7FF, 21'h80));
      3: begin
        do cp = 21'($urandom_range(21'hFFFF, 21'h800));
        while (cp >= 21'hD800 && cp <= 21'hDFFF);
      end
      default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
    endcase
    put_encoded(cp, nbytes);
  endtask

  // malformed piece of input
  task automatic put_broken_char();
    logic [20:0] cp;
    int          nbytes;
    int          drop;
    case ($urandom_range(6))
      0: append_byte(8'($urandom_range(255)));
      1: begin
        // truncated, the next character or the string end breaks it
        nbytes = $urandom_range(4, 2);
        cp = (nbytes == 2) ? 21'(21'h80 + $urandom_range(21'h77F)) :
             (nbytes == 3) ? 21'(21'h800 + $urandom_range(21'h3FFF)) :
                             21'(21'h10000 + $urandom_range(21'hFFFFF));
        put_encoded(cp, nbytes);
        drop = $urandom_range(nbytes - 1, 1);
        repeat (drop) void'(text.pop_back());
      end
      2: begin
        // overlong form
        nbytes = $urandom_range(4, 2);
        cp = (nbytes == 2) ? 21'($urandom_range(21'h7F)) :
             (nbytes == 3) ? 21'($urandom_range(21'h7FF)) : 21'($urandom_range(21'hFFFF));
        put_encoded(cp, nbytes);
      end
      3: put_encoded(21'($urandom_range(21'hDFFF, 21'hD800)), 3);
      4: put_encoded(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
      5: append_byte({2'b10, 6'($urandom_range(63))});
      default: append_byte(8'($urandom_range(255, 248)));
    endcase
  endtask

  // strings of one to six characters, about one in five malformed
  task automatic run_random_phase(input int until_bytes);
    int nchar;
    int start;
    while (rand_bytes < until_bytes) begin
      nchar = $urandom_range(6, 1);
      repeat (nchar) begin
        if ($urandom_range(99) < 20) put_broken_char();
        else put_valid_char();
      end
      start = bytes_sent;
      send_text();
      rand_bytes += bytes_sent - start;
    end
  endtask

  initial begin
    int i;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under the first idle mix
    for (i = 0; i < DirLen; i++) append_byte(DirectedText[(DirLen-1-i)*8 +: 8]);
    send_text();
    append_byte(8'h7F);
    send_text();

    // sender idles less than the receiver
    run_random_phase(RandBytes / 3);
    // the other way round
    send_idle_pct = 53;
    recv_idle_pct = 30;
    run_random_phase(2 * RandBytes / 3);
    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(RandBytes);
    push <= 1'b0;

    // wait for every expected code unit, then let stray output show up
    do @(posedge clk_i); while (units_waiting != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d bytes in %0d strings, %0d code units checked, %0d mismatches",
             bytes_sent, texts_sent, units_checked, error_count);
    $display("mix of well-formed text and malformed bytes under three idle patterns");
    if (error_count == 0 && units_waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: utf8_to_utf16_transcoder.f
+incdir+hw/rtl
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_cmd_fifo.sv
hw/rtl/u8u16_front.sv
hw/rtl/u8u16_back.sv
hw/rtl/utf8_to_utf16_transcoder.sv
verif/utf16_unit_checker.sv
verif/tb.sv
